>>> design/fbpa_pkg.sv
`timescale 1ns / 1ps
package fbpa_pkg;

    localparam int TOTAL_BLOCKS_DEF   = 256;
    localparam int FIRST_CHUNK_BLOCKS = 5;

    localparam int IDX_W   = 8;
    localparam int OFF_W   = 20;
    localparam int BPC_W   = 7;
    localparam int BSIZE_W = 13;

    localparam logic [BPC_W-1:0]   BPC_RESET   = 7'd5;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd16;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCKS_PER_CHUNK = 1'b0;
    localparam logic REG_BLOCK_SIZE       = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OOM       = 2'd1,
        ST_NULL_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic [BPC_W-1:0]   blocks_per_chunk;
        logic [BSIZE_W-1:0] block_size;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // input transaction taken, latch fields and read link
        logic commit;   // execute the request and load the output register
    } t_cmd;

endpackage

>>> design/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// A request is accepted in IDLE (fields latched, link store read) and runs in EXEC once
// the output register is free, loading its result there. No new request is taken until
// then, as the link store is written on execute and the next free-list head needs that read.
// Reset: i_rst_n synchronous, active low; empties the freed stack, rewinds the carve pointer,
// opens the first chunk and restores the registers. The link store is not cleared.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int TOTAL_BLOCKS = TOTAL_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] free_index
    input  logic [1:0]  i_s_tuser,   // [0] mode, [1] free_is_null
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] block_index, [27:8] byte_offset, [31:28] zero
    output logic [2:0]  o_m_tuser,   // [1:0] status, [2] chunk_added
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg             cfg;
    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] block_index;
    logic [OFF_W-1:0] byte_offset;
    logic             chunk_added;

    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    fbpa_datapath #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_mode         (i_s_tuser[0]),
        .i_free_index   (i_s_tdata),
        .i_free_is_null (i_s_tuser[1]),
        .o_status       (status),
        .o_block_index  (block_index),
        .o_byte_offset  (byte_offset),
        .o_chunk_added  (chunk_added)
    );

    assign o_m_tdata = {4'b0000, byte_offset, block_index};
    assign o_m_tuser = {chunk_added, status};

endmodule

>>> design/fbpa_regs.sv
`timescale 1ns / 1ps
module fbpa_regs
    import fbpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [BPC_W-1:0]   r_blocks_per_chunk;
    logic [BSIZE_W-1:0] r_block_size;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_per_chunk <= BPC_RESET;
            r_block_size       <= BSIZE_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BLOCKS_PER_CHUNK: r_blocks_per_chunk <= pwdata[BPC_W-1:0];
                REG_BLOCK_SIZE:       r_block_size       <= pwdata[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCKS_PER_CHUNK: prdata = 32'(r_blocks_per_chunk);
            REG_BLOCK_SIZE:       prdata = 32'(r_block_size);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.blocks_per_chunk = r_blocks_per_chunk;
    assign o_cfg.block_size       = r_block_size;

endmodule

>>> design/fbpa_ctrl.sv
`timescale 1ns / 1ps
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_s_tready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_s_tvalid;
    // hold in EXEC until the output register can take the result
    assign out_free      = !r_out_valid || i_m_tready;
    assign o_cmd.commit  = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_EXEC;
            S_EXEC: if (out_free)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> design/fbpa_datapath.sv
`timescale 1ns / 1ps
module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int TOTAL_BLOCKS = TOTAL_BLOCKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_cfg             i_cfg,
    input  logic             i_mode,
    input  logic [IDX_W-1:0] i_free_index,
    input  logic             i_free_is_null,
    output t_status          o_status,
    output logic [IDX_W-1:0] o_block_index,
    output logic [OFF_W-1:0] o_byte_offset,
    output logic             o_chunk_added
);

    // only indices below 256 can come back through a free
    localparam int LINK_DEPTH = (TOTAL_BLOCKS < 256) ? TOTAL_BLOCKS : 256;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int CNT_W      = $clog2(TOTAL_BLOCKS + 1);
    localparam logic [16:0] TOTAL_L = 17'(TOTAL_BLOCKS);
    localparam logic [BPC_W-1:0] LEFT_RESET =
        BPC_W'((FIRST_CHUNK_BLOCKS < TOTAL_BLOCKS) ? FIRST_CHUNK_BLOCKS : TOTAL_BLOCKS);

    // link entry: valid bit over block index
    logic [IDX_W:0]     r_link [LINK_DEPTH];
    logic [IDX_W:0]     r_link_rd;
    logic [IDX_W:0]     r_top, n_top;
    logic [CNT_W-1:0]   r_carve_next, n_carve_next;
    logic [BPC_W-1:0]   r_carve_left, n_carve_left;

    logic               r_mode;
    logic [IDX_W-1:0]   r_fidx;
    logic               r_fnull;

    t_status            r_status;
    logic [IDX_W-1:0]   r_idx;
    logic [OFF_W-1:0]   r_off;
    logic               r_added;

    logic [BPC_W-1:0]   chunk_n;
    logic               fits;
    logic [BPC_W-1:0]   left_eff;
    logic               opened;
    logic               push;
    t_status            res_status;
    logic [IDX_W-1:0]   res_idx;
    logic               res_added;
    logic [20:0]        prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_fidx    <= i_free_index;
            r_fnull   <= i_free_is_null;
            r_link_rd <= r_link[r_top[LINK_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && push) begin
            r_link[r_fidx[LINK_AW-1:0]] <= r_top;
        end
    end

    assign chunk_n  = (i_cfg.blocks_per_chunk == '0) ? BPC_W'(1) : i_cfg.blocks_per_chunk;
    assign fits     = (17'(r_carve_next) + 17'(chunk_n)) <= TOTAL_L;
    assign opened   = (r_carve_left == '0) && fits;
    assign left_eff = opened ? chunk_n : r_carve_left;

    always_comb begin
        n_top        = r_top;
        n_carve_next = r_carve_next;
        n_carve_left = r_carve_left;
        push         = 1'b0;
        res_status   = ST_DONE;
        res_idx      = '0;
        res_added    = 1'b0;
        if (r_mode == MODE_FREE) begin
            if (r_fnull || (17'(r_fidx) >= TOTAL_L)) begin
                res_status = ST_NULL_FREE;
            end else begin
                push  = 1'b1;
                n_top = {1'b1, r_fidx};
            end
        end else if (r_top[IDX_W]) begin
            // pop the most recently freed block
            res_idx = r_top[IDX_W-1:0];
            n_top   = r_link_rd;
        end else if ((left_eff != '0) && (17'(r_carve_next) < TOTAL_L)) begin
            res_idx      = IDX_W'(r_carve_next);
            res_added    = opened;
            n_carve_next = r_carve_next + CNT_W'(1);
            n_carve_left = left_eff - BPC_W'(1);
        end else begin
            res_status = ST_OOM;
        end
    end

    assign prod = 21'(res_idx) * 21'(i_cfg.block_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top        <= '0;
            r_carve_next <= '0;
            r_carve_left <= LEFT_RESET;
        end else if (i_cmd.commit) begin
            r_top        <= n_top;
            r_carve_next <= n_carve_next;
            r_carve_left <= n_carve_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_idx    <= res_idx;
            r_off    <= prod[OFF_W-1:0];
            r_added  <= res_added;
        end
    end

    assign o_status      = r_status;
    assign o_block_index = r_idx;
    assign o_byte_offset = r_off;
    assign o_chunk_added = r_added;

endmodule

>>> tb/sv/fbpa_pool_checker.sv
`timescale 1ns / 1ps
module fbpa_pool_checker
    import fbpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] free_index
    input  logic [1:0]  i_s_tuser,   // [0] mode, [1] free_is_null
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [7:0] block_index, [27:8] byte_offset, [31:28] zero
    input  logic [2:0]  i_m_tuser,   // [1:0] status, [2] chunk_added
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_chunks,
    output int          o_oom,
    output int          o_ignored
);

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [OFF_W-1:0]   offset;
        logic               chunk_added;
    } t_grant;

    // shadow registers and pool state
    logic [BPC_W-1:0]   shadow_bpc;
    logic [BSIZE_W-1:0] shadow_bsize;
    logic [IDX_W:0]     link_mem [TOTAL_BLOCKS_DEF];
    logic [IDX_W:0]     freed_head;    // [IDX_W] valid, rest index
    int unsigned        carve_next;
    int unsigned        carve_left;

    t_grant grant_q[$];
    t_grant want;
    t_grant got;
    logic [31:0] reg_value;

    function automatic t_grant serve_request(input logic mode, input logic [IDX_W-1:0] fidx,
                                             input logic fnull);
        t_grant      r;
        int unsigned span;
        logic        given;
        r     = '0;
        given = 1'b0;
        if (mode == MODE_FREE) begin
            if (fnull || int'(fidx) >= TOTAL_BLOCKS_DEF) begin
                r.status = ST_NULL_FREE;
            end else begin
                link_mem[fidx] = freed_head;
                freed_head     = {1'b1, fidx};
            end
        end else if (freed_head[IDX_W]) begin
            r.index    = freed_head[IDX_W-1:0];
            freed_head = link_mem[r.index];
            given      = 1'b1;
        end else begin
            if (carve_left == 0) begin
                // a zero chunk size acts as one block
                span = (shadow_bpc == 0) ? 1 : shadow_bpc;
                if (carve_next + span <= TOTAL_BLOCKS_DEF) begin
                    carve_left    = span;
                    r.chunk_added = 1'b1;
                end
            end
            if (carve_left != 0 && carve_next < TOTAL_BLOCKS_DEF) begin
                r.index    = IDX_W'(carve_next);
                carve_next = carve_next + 1;
                carve_left = carve_left - 1;
                given      = 1'b1;
            end else begin
                r.status      = ST_OOM;
                r.chunk_added = 1'b0;
            end
        end
        if (given)
            r.offset = OFF_W'(32'(r.index) * 32'(shadow_bsize));
        else
            r.index = '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_bpc   = BPC_RESET;
            shadow_bsize = BSIZE_RESET;
            freed_head   = '0;
            carve_next   = 0;
            carve_left   = (FIRST_CHUNK_BLOCKS < TOTAL_BLOCKS_DEF) ?
                           FIRST_CHUNK_BLOCKS : TOTAL_BLOCKS_DEF;
            grant_q.delete();
            o_fail_count = 0;
            o_results    = 0;
            o_chunks     = 0;
            o_oom        = 0;
            o_ignored    = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_BLOCK_SIZE)
                        shadow_bsize = pwdata[BSIZE_W-1:0];
                    else
                        shadow_bpc = pwdata[BPC_W-1:0];
                end else begin
                    reg_value = (paddr[2] == REG_BLOCK_SIZE) ? 32'(shadow_bsize)
                                                             : 32'(shadow_bpc);
                    if (prdata !== reg_value) begin
                        $error("prdata: expected %0d, got %0d", reg_value, prdata);
                        o_fail_count++;
                    end
                end
            end

            // retire results before taking new requests: no result leaves in its accept cycle
            if (i_m_tvalid && i_m_tready) begin
                got.status      = t_status'(i_m_tuser[1:0]);
                got.chunk_added = i_m_tuser[2];
                got.index       = i_m_tdata[7:0];
                got.offset      = i_m_tdata[27:8];
                if (grant_q.size() == 0) begin
                    $error("unexpected result transaction: status %0d index %0d",
                           got.status, got.index);
                    o_fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    o_results++;
                    if (want.chunk_added) o_chunks++;
                    if (want.status == ST_OOM) o_oom++;
                    if (want.status == ST_NULL_FREE) o_ignored++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.index !== want.index) begin
                        $error("block_index: expected %0d, got %0d", want.index, got.index);
                        o_fail_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("byte_offset: expected %0d, got %0d", want.offset, got.offset);
                        o_fail_count++;
                    end
                    if (got.chunk_added !== want.chunk_added) begin
                        $error("chunk_added: expected %0d, got %0d",
                               want.chunk_added, got.chunk_added);
                        o_fail_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready)
                grant_q.push_back(serve_request(i_s_tuser[0], i_s_tdata, i_s_tuser[1]));
        end
        o_pending = grant_q.size();
    end

endmodule

>>> tb/sv/fixed_block_pool_allocator_unit_tb.sv
`timescale 1ns / 1ps
module fixed_block_pool_allocator_unit_tb;
    import fbpa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] free_index
    logic [1:0]  i_s_tuser;   // [0] mode, [1] free_is_null
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [7:0] block_index, [27:8] byte_offset, [31:28] zero
    logic [2:0]  o_m_tuser;   // [1:0] status, [2] chunk_added
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_seen;
    int chunks_seen;
    int oom_seen;
    int ignored_seen;

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic sent_modes[$];
    logic [7:0] live_blocks[$];

    fixed_block_pool_allocator_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    fbpa_pool_checker pool_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results_seen),
        .o_chunks    (chunks_seen),
        .o_oom       (oom_seen),
        .o_ignored   (ignored_seen)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("fixed_block_pool_allocator_unit verification failed");
        $finish;
    end

    // result side: stall in random bursts
    always begin
        @(negedge i_clk);
        if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            i_m_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    // collect handed-out blocks so that most frees return a block in use
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready && sent_modes.size() != 0) begin
            if (sent_modes.pop_front() == MODE_ALLOC && o_m_tuser[1:0] == ST_DONE)
                live_blocks.push_back(o_m_tdata[7:0]);
        end
    end

    task automatic send_request(input logic mode, input logic [7:0] fidx, input logic fnull);
        @(negedge i_clk);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= fidx;
        i_s_tuser  <= {fnull, mode};
        do @(posedge i_clk); while (!o_s_tready);
        sent_modes.push_back(mode);
    endtask

    task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // upper data bits carry noise: the block keeps only the register width
    task automatic set_pool_config(input logic [BPC_W-1:0] bpc, input logic [BSIZE_W-1:0] bsize);
        wait_drained();
        apb_access(1'b1, REG_BLOCKS_PER_CHUNK, ($urandom() & 32'hFFFF_FF80) | 32'(bpc));
        apb_access(1'b1, REG_BLOCK_SIZE, ($urandom() & 32'hFFFF_E000) | 32'(bsize));
        apb_access(1'b0, REG_BLOCKS_PER_CHUNK, '0);
        apb_access(1'b0, REG_BLOCK_SIZE, '0);
    endtask

    task automatic run_random(input int n_items, input int alloc_pct);
        int         done_n;
        int         pick;
        int         j;
        logic [7:0] fidx;
        done_n = 0;
        while (done_n < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                send_request(MODE_ALLOC, 8'($urandom()), 1'($urandom()));
                done_n++;
            end else if (pick < 92 && live_blocks.size() != 0) begin
                j    = $urandom_range(0, live_blocks.size() - 1);
                fidx = live_blocks[j];
                live_blocks.delete(j);
                send_request(MODE_FREE, fidx, 1'b0);
                done_n++;
            end else if (pick < 96) begin
                // null free, ignored by the block
                send_request(MODE_FREE, 8'($urandom()), 1'b1);
            end else begin
                // free of an arbitrary block, possibly one never handed out
                send_request(MODE_FREE, 8'($urandom()), 1'b0);
                done_n++;
            end
        end
    endtask

    initial begin
        int phase;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: carve the first chunk, open the second, LIFO reuse
        repeat (6) send_request(MODE_ALLOC, 8'h00, 1'b0);
        send_request(MODE_FREE, 8'hFF, 1'b1);
        send_request(MODE_FREE, 8'd3, 1'b0);
        send_request(MODE_FREE, 8'd0, 1'b0);
        send_request(MODE_ALLOC, 8'hFF, 1'b1);
        send_request(MODE_ALLOC, 8'h00, 1'b0);
        send_request(MODE_FREE, 8'hFF, 1'b0);
        send_request(MODE_ALLOC, 8'h00, 1'b0);
        send_request(MODE_ALLOC, 8'hFF, 1'b1);

        // zero chunk size and largest block size: offset wraps, single-block chunks
        set_pool_config(7'd0, 13'h1FFF);
        send_request(MODE_FREE, 8'hFF, 1'b0);
        repeat (6) send_request(MODE_ALLOC, 8'h5A, 1'b0);

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_pool_config(7'd1, 13'd1);
                1: set_pool_config(7'd64, 13'd4096);
                2: set_pool_config(7'($urandom_range(2, 20)), 13'($urandom_range(1, 8191)));
                3: set_pool_config(7'd127, 13'h1FFF);
                default: set_pool_config(7'($urandom_range(0, 64)),
                                         13'($urandom_range(1, 4096)));
            endcase
            if (phase == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                run_random(190, 70);
            end else begin
                tx_idle_pct = 15 * $urandom_range(0, 2);
                rx_idle_pct = 15 * $urandom_range(0, 2);
                run_random(190, 50);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d results: %0d chunk openings, %0d out-of-memory answers,",
                 results_seen, chunks_seen, oom_seen);
        $display("%0d ignored frees, across seven register settings", ignored_seen);
        if (fail_count == 0 && pending == 0)
            $display("fixed_block_pool_allocator_unit verification clean");
        else
            $display("fixed_block_pool_allocator_unit verification failed");
        $finish;
    end

endmodule

>>> files.f
design/fbpa_pkg.sv
design/fbpa_regs.sv
design/fbpa_ctrl.sv
design/fbpa_datapath.sv
design/fixed_block_pool_allocator_unit.sv
tb/sv/fbpa_pool_checker.sv
tb/sv/fixed_block_pool_allocator_unit_tb.sv
